// File: src/ehe_pkg.sv
// Shared types and codes for the event histogram engine.
`default_nettype none

package ehe_pkg;

  // Fixed port widths
  localparam int unsigned EventW   = 8;
  localparam int unsigned EventNum = 256;
  localparam int unsigned SizeW    = 9;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned TotalW   = 40;
  localparam int unsigned ProbW    = 17;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned KindW    = 2;

  localparam logic [SizeW-1:0] SupportReset = 9'd256;

  // Operation codes
  localparam logic [KindW-1:0] KIND_TICK = 2'd0;
  localparam logic [KindW-1:0] KIND_SET  = 2'd1;
  localparam logic [KindW-1:0] KIND_GET  = 2'd2;
  localparam logic [KindW-1:0] KIND_PROB = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] STATUS_OK     = 2'd0;
  localparam logic [StatusW-1:0] STATUS_RANGE  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NO_OBS = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_en;
    logic div_start;
    logic finish;
  } ehe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic need_div;
    logic div_done;
  } ehe_status_t;

endpackage

`default_nettype wire

// File: src/event_histogram_engine.sv
// Top level of the event histogram engine.
//
// A word is taken at a rising edge with start high and busy low. Tick, set and
// get words pass through the exec state after the accept: the bin read is
// registered at the accept, and the update and write back follow in exec. A
// probability word with a nonzero total runs the restoring divider, one
// quotient bit per cycle, before it finishes. Each result is shown for exactly one
// cycle with done_o high, in the cycle after its last work cycle; the receiver
// cannot stall it, so it must take every result as it comes. After reset a
// clearing pass zeroes all min(BINS, 256) entries of the bin store with busy
// high; support size writes are taken during it.
`default_nettype none

module event_histogram_engine #(
  parameter int unsigned BINS           = 256,
  parameter int unsigned COUNT_WIDTH    = 32,
  parameter int unsigned PROB_FRAC_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ehe_pkg::SizeW-1:0]      cfg_wdata_i,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ehe_pkg::KindW-1:0]      kind_i,
  input  wire logic [ehe_pkg::EventW-1:0]     event_req_i,
  input  wire logic [ehe_pkg::ValueW-1:0]     value_i,
  output logic                                done_o,
  output logic [ehe_pkg::CountW-1:0]          count_o,
  output logic [ehe_pkg::TotalW-1:0]          total_o,
  output logic [ehe_pkg::ProbW-1:0]           probability_o,
  output logic [ehe_pkg::StatusW-1:0]         status_o
);

  ehe_pkg::ehe_cmd_t    cmd;
  ehe_pkg::ehe_status_t sts;

  ehe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ehe_datapath #(
    .BINS           (BINS),
    .COUNT_WIDTH    (COUNT_WIDTH),
    .PROB_FRAC_BITS (PROB_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .event_req_i   (event_req_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .count_o       (count_o),
    .total_o       (total_o),
    .probability_o (probability_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

// File: src/ehe_divider.sv
// Restoring fractional divider, one quotient bit per cycle.
`default_nettype none

module ehe_divider #(
  parameter int unsigned W  = 40,
  parameter int unsigned QW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [W-1:0]  num_i,
  input  wire logic [W-1:0]  den_i,
  output logic               done_o,
  output logic [QW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(QW);

  logic            running_q, running_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    den_q, den_d;
  logic [QW-1:0]   quot_q, quot_d;

  logic [W:0]      trial;
  logic            ge;

  // First step compares the numerator itself, later ones the doubled remainder
  always_comb begin
    trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge    = trial >= {1'b0, den_q};
  end

  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    den_d     = den_q;
    quot_d    = quot_q;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = '0;
      rem_d     = num_i;
      den_d     = den_i;
    end else if (running_q) begin
      rem_d  = ge ? W'(trial - {1'b0, den_q}) : W'(trial);
      quot_d = {quot_q[QW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(QW - 1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  // Datapath flops
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: src/ehe_datapath.sv
// Bin store, running total, range check, divider and result registers.
`default_nettype none

module ehe_datapath #(
  parameter int unsigned BINS           = 256,
  parameter int unsigned COUNT_WIDTH    = 32,
  parameter int unsigned PROB_FRAC_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ehe_pkg::ehe_cmd_t                cmd_i,
  output ehe_pkg::ehe_status_t                  sts_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ehe_pkg::SizeW-1:0]        cfg_wdata_i,
  input  wire logic [ehe_pkg::KindW-1:0]        kind_i,
  input  wire logic [ehe_pkg::EventW-1:0]       event_req_i,
  input  wire logic [ehe_pkg::ValueW-1:0]       value_i,
  output logic                                  done_o,
  output logic [ehe_pkg::CountW-1:0]            count_o,
  output logic [ehe_pkg::TotalW-1:0]            total_o,
  output logic [ehe_pkg::ProbW-1:0]             probability_o,
  output logic [ehe_pkg::StatusW-1:0]           status_o
);

  // Only bins an event index can reach are stored
  localparam int unsigned MemDepth = (BINS < ehe_pkg::EventNum) ? BINS : ehe_pkg::EventNum;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned TotW     = COUNT_WIDTH + $clog2(BINS);
  localparam int unsigned QuotW    = PROB_FRAC_BITS + 1;

  logic [COUNT_WIDTH-1:0]      mem [MemDepth];
  logic [COUNT_WIDTH-1:0]      rd_q;

  logic [ehe_pkg::SizeW-1:0]   support_q;
  logic [TotW-1:0]             total_q, total_d;
  logic [AddrW-1:0]            clr_addr_q;
  logic [AddrW-1:0]            addr_q;
  logic [ehe_pkg::KindW-1:0]   kind_q;
  logic                        in_range_q;
  logic [COUNT_WIDTH-1:0]      val_q;

  logic                        done_q;
  logic [ehe_pkg::CountW-1:0]  count_q, count_d;
  logic [ehe_pkg::TotalW-1:0]  tot_out_q;
  logic [ehe_pkg::ProbW-1:0]   prob_q, prob_d;
  logic [ehe_pkg::StatusW-1:0] status_q, status_d;

  logic                        in_range;
  logic                        sat;
  logic                        upd_tick, upd_set;
  logic                        we;
  logic [AddrW-1:0]            waddr;
  logic [COUNT_WIDTH-1:0]      wdata;
  logic [COUNT_WIDTH-1:0]      new_cnt;
  logic                        div_done;
  logic [QuotW-1:0]            quot;

  // Range check against the configured support and the bin count
  assign in_range = ({1'b0, event_req_i} < support_q) && (32'(event_req_i) < 32'(BINS));

  // Update decode for the word in flight
  always_comb begin
    sat      = (rd_q == '1);
    upd_tick = in_range_q && (kind_q == ehe_pkg::KIND_TICK) && !sat;
    upd_set  = in_range_q && (kind_q == ehe_pkg::KIND_SET);
    new_cnt  = upd_set ? val_q : (upd_tick ? rd_q + 1'b1 : rd_q);
    total_d  = total_q;
    if (upd_tick) begin
      total_d = total_q + 1'b1;
    end else if (upd_set) begin
      total_d = total_q - TotW'(rd_q) + TotW'(val_q);
    end
  end

  // Bin store write port: clearing pass or the update
  always_comb begin
    we    = cmd_i.clear_en || (cmd_i.finish && (upd_tick || upd_set));
    waddr = cmd_i.clear_en ? clr_addr_q : addr_q;
    wdata = cmd_i.clear_en ? '0 : new_cnt;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[event_req_i[AddrW-1:0]];
    end
  end

  // Captured operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= event_req_i[AddrW-1:0];
      kind_q <= kind_i;
      val_q  <= COUNT_WIDTH'(value_i);
    end
  end

  // Control state: range flag, total, clear sweep, configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_range_q <= 1'b0;
      total_q    <= '0;
      clr_addr_q <= '0;
      support_q  <= ehe_pkg::SupportReset;
    end else begin
      if (cmd_i.accept) begin
        in_range_q <= in_range;
      end
      if (cmd_i.finish) begin
        total_q <= total_d;
      end
      if (cmd_i.clear_en) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cfg_we_i) begin
        support_q <= cfg_wdata_i;
      end
    end
  end

  // Probability unit
  ehe_divider #(
    .W  (TotW),
    .QW (QuotW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (TotW'(rd_q)),
    .den_i   (total_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Status back to the controller
  always_comb begin
    sts_o.clear_last = (clr_addr_q == AddrW'(MemDepth - 1));
    sts_o.need_div   = in_range_q && (kind_q == ehe_pkg::KIND_PROB) && (total_q != '0);
    sts_o.div_done   = div_done;
  end

  // Result word
  always_comb begin
    count_d  = '0;
    prob_d   = '0;
    status_d = ehe_pkg::STATUS_OK;
    if (!in_range_q) begin
      status_d = ehe_pkg::STATUS_RANGE;
    end else begin
      count_d = ehe_pkg::CountW'(new_cnt);
      if (kind_q == ehe_pkg::KIND_PROB) begin
        if (total_q == '0) begin
          status_d = ehe_pkg::STATUS_NO_OBS;
        end else begin
          prob_d = ehe_pkg::ProbW'(quot);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      count_q   <= count_d;
      tot_out_q <= ehe_pkg::TotalW'(total_d);
      prob_q    <= prob_d;
      status_q  <= status_d;
    end
  end

  assign done_o        = done_q;
  assign count_o       = count_q;
  assign total_o       = tot_out_q;
  assign probability_o = prob_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

// File: src/ehe_ctrl.sv
// Sequencer: clearing pass, read, optional divide, result.
`default_nettype none

module ehe_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ehe_pkg::ehe_status_t sts_i,
  output ehe_pkg::ehe_cmd_t         cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o.accept    = 1'b0;
    cmd_o.clear_en  = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.finish    = 1'b0;
    busy            = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // bin word is in the read register now
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/event_histogram_engine_tb.sv
// Self-checking testbench for the event histogram engine.
`timescale 1ns / 1ps

module event_histogram_engine_tb;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned SettleCyc  = 40;
  localparam int unsigned RandWords  = 250;

  // One result word as seen on the output ports
  typedef struct packed {
    logic [ehe_pkg::CountW-1:0]  count;
    logic [ehe_pkg::TotalW-1:0]  total;
    logic [ehe_pkg::ProbW-1:0]   prob;
    logic [ehe_pkg::StatusW-1:0] status;
  } bin_report_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [ehe_pkg::SizeW-1:0]    cfg_wdata_i;
  logic                         start;
  logic                         busy;
  logic [ehe_pkg::KindW-1:0]    kind_i;
  logic [ehe_pkg::EventW-1:0]   event_req_i;
  logic [ehe_pkg::ValueW-1:0]   value_i;
  logic                         done_o;
  logic [ehe_pkg::CountW-1:0]   count_o;
  logic [ehe_pkg::TotalW-1:0]   total_o;
  logic [ehe_pkg::ProbW-1:0]    probability_o;
  logic [ehe_pkg::StatusW-1:0]  status_o;

  // Shadow histogram and the reports it predicts
  logic [ehe_pkg::CountW-1:0]   shadow_bins [ehe_pkg::EventNum];
  logic [ehe_pkg::TotalW-1:0]   shadow_total;
  logic [ehe_pkg::SizeW-1:0]    shadow_support;
  bin_report_t                  pending_reports [$];

  int unsigned         sender_idle_pct;
  int unsigned         quiet_cycles;
  int unsigned         mismatch_cnt;

  event_histogram_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .event_req_i   (event_req_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .count_o       (count_o),
    .total_o       (total_o),
    .probability_o (probability_o),
    .status_o      (status_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Update the shadow histogram for one accepted word and queue its report
  task automatic predict_report(input logic [ehe_pkg::KindW-1:0] kind,
                                input logic [ehe_pkg::EventW-1:0] ev,
                                input logic [ehe_pkg::ValueW-1:0] val);
    bin_report_t      rep;
    int unsigned      bound;
    longint unsigned  quot;
    rep   = '0;
    bound = (shadow_support > ehe_pkg::EventNum) ? ehe_pkg::EventNum : shadow_support;
    if (ev >= bound) begin
      rep.status = ehe_pkg::STATUS_RANGE;
    end else begin
      case (kind)
        ehe_pkg::KIND_TICK: begin
          // saturate, total untouched on a full bin
          if (shadow_bins[ev] != '1) begin
            shadow_bins[ev] = shadow_bins[ev] + 1'b1;
            shadow_total    = shadow_total + 1'b1;
          end
          rep.count = shadow_bins[ev];
        end
        ehe_pkg::KIND_SET: begin
          shadow_total    = shadow_total - shadow_bins[ev] + val;
          shadow_bins[ev] = val;
          rep.count       = val;
        end
        ehe_pkg::KIND_GET: begin
          rep.count = shadow_bins[ev];
        end
        default: begin
          rep.count = shadow_bins[ev];
          if (shadow_total == '0) begin
            rep.status = ehe_pkg::STATUS_NO_OBS;
          end else begin
            // bin never exceeds total, so the quotient fits in 17 bits
            quot     = (longint'(shadow_bins[ev]) << FracBits) / longint'(shadow_total);
            rep.prob = quot[ehe_pkg::ProbW-1:0];
          end
        end
      endcase
    end
    rep.total = shadow_total;
    pending_reports.push_back(rep);
  endtask

  // Send one word; called and returns at a falling edge
  task automatic send_word(input logic [ehe_pkg::KindW-1:0] kind,
                           input logic [ehe_pkg::EventW-1:0] ev,
                           input logic [ehe_pkg::ValueW-1:0] val);
    bit idled;
    idled = 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      if (!idled) start = 1'b0;
      idled = 1'b1;
      @(negedge clk_i);
    end
    kind_i      = kind;
    event_req_i = ev;
    value_i     = val;
    start       = 1'b1;
    do @(posedge clk_i); while (busy);
    predict_report(kind, ev, val);
    @(negedge clk_i);
  endtask

  // Stop sending and let every report come back
  task automatic drain_reports();
    start = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // Support size write, made with the engine idle or during the clearing pass
  task automatic write_support(input logic [ehe_pkg::SizeW-1:0] size);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = size;
    @(negedge clk_i);
    cfg_we_i       = 1'b0;
    shadow_support = size;
  endtask

  // Fresh histogram: empty-total probability, corner bins, wide values
  task automatic test_empty_and_extremes();
    sender_idle_pct = 0;
    send_word(ehe_pkg::KIND_PROB, 8'd0, '1);
    send_word(ehe_pkg::KIND_GET, 8'd255, 32'h0);
    send_word(ehe_pkg::KIND_TICK, 8'd0, 32'h0);
    send_word(ehe_pkg::KIND_PROB, 8'd0, 32'h0);
    send_word(ehe_pkg::KIND_PROB, 8'd1, 32'h0);
    send_word(ehe_pkg::KIND_SET, 8'd7, 32'h5555_5555);
    send_word(ehe_pkg::KIND_SET, 8'd7, 32'hAAAA_AAAA);
    send_word(ehe_pkg::KIND_GET, 8'd7, '1);
    send_word(ehe_pkg::KIND_PROB, 8'd7, 32'h0);
    send_word(ehe_pkg::KIND_SET, 8'd7, 32'h0);
  endtask

  // Ticks on a full bin hold the count and the total
  task automatic test_saturation();
    send_word(ehe_pkg::KIND_SET, 8'd255, '1);
    send_word(ehe_pkg::KIND_TICK, 8'd255, 32'h0);
    send_word(ehe_pkg::KIND_PROB, 8'd255, 32'h0);
    send_word(ehe_pkg::KIND_SET, 8'd128, 32'hFFFF_FFFE);
    send_word(ehe_pkg::KIND_TICK, 8'd128, 32'h0);
    send_word(ehe_pkg::KIND_TICK, 8'd128, 32'h0);
    send_word(ehe_pkg::KIND_PROB, 8'd0, 32'h0);
  endtask

  // Range bound: zero, one, above the bin count; bins outside keep their counts
  task automatic test_support_bounds();
    drain_reports();
    write_support(9'd1);
    send_word(ehe_pkg::KIND_GET, 8'd0, 32'h0);
    send_word(ehe_pkg::KIND_TICK, 8'd1, 32'h0);
    send_word(ehe_pkg::KIND_PROB, 8'd255, 32'h0);
    drain_reports();
    write_support(9'd0);
    send_word(ehe_pkg::KIND_SET, 8'd0, '1);
    send_word(ehe_pkg::KIND_PROB, 8'd0, 32'h0);
    drain_reports();
    write_support(9'd511);
    send_word(ehe_pkg::KIND_GET, 8'd255, 32'h0);
    send_word(ehe_pkg::KIND_SET, 8'd255, 32'h0);
    send_word(ehe_pkg::KIND_PROB, 8'd128, 32'h0);
    drain_reports();
  endtask

  // Random word mix under one support size and one sender idle rate
  task automatic test_random_traffic(input int unsigned n, input int unsigned idle_pct,
                                     input logic [ehe_pkg::SizeW-1:0] size);
    logic [ehe_pkg::KindW-1:0]  kind;
    logic [ehe_pkg::EventW-1:0] ev;
    logic [ehe_pkg::ValueW-1:0] val;
    int unsigned                bound;
    int unsigned                pick;
    drain_reports();
    write_support(size);
    sender_idle_pct = idle_pct;
    bound = (size > ehe_pkg::EventNum) ? ehe_pkg::EventNum : size;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40)      kind = ehe_pkg::KIND_TICK;
      else if (pick < 55) kind = ehe_pkg::KIND_SET;
      else if (pick < 75) kind = ehe_pkg::KIND_GET;
      else                kind = ehe_pkg::KIND_PROB;
      // mostly in range, some stray events
      if (bound == 0 || $urandom_range(9) == 0) ev = $urandom_range(255);
      else                                     ev = $urandom_range(bound - 1);
      case ($urandom_range(4))
        0:       val = $urandom();
        1:       val = $urandom_range(1000);
        2:       val = 32'hFFFF_FFFF - $urandom_range(3);
        3:       val = '0;
        default: val = $urandom_range(20);
      endcase
      send_word(kind, ev, val);
    end
  endtask

  // Report checker
  always @(posedge clk_i) begin
    bin_report_t want;
    if (done_o === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word: count %0h total %0h", count_o, total_o);
        mismatch_cnt++;
      end else begin
        want = pending_reports.pop_front();
        if (count_o !== want.count) begin
          $error("count: expected %0h, got %0h", want.count, count_o);
          mismatch_cnt++;
        end
        if (total_o !== want.total) begin
          $error("total: expected %0h, got %0h", want.total, total_o);
          mismatch_cnt++;
        end
        if (probability_o !== want.prob) begin
          $error("probability: expected %0h, got %0h", want.prob, probability_o);
          mismatch_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    start           = 1'b0;
    kind_i          = ehe_pkg::KIND_TICK;
    event_req_i     = '0;
    value_i         = '0;
    sender_idle_pct = 0;
    quiet_cycles    = 0;
    mismatch_cnt    = 0;
    shadow_total    = '0;
    shadow_support  = ehe_pkg::SupportReset;
    foreach (shadow_bins[i]) shadow_bins[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    // taken during the clearing pass
    write_support(9'd256);

    test_empty_and_extremes();
    test_saturation();
    test_support_bounds();
    test_random_traffic(RandWords, 27, 9'd16);
    test_random_traffic(RandWords, 53, 9'($urandom_range(255, 1)));
    test_random_traffic(RandWords, 0, 9'd256);
    drain_reports();

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
